### hw/rtl/seven_segment_decimal_scan_core_defines.svh
// Assertion macros shared by the seven-segment scan core.
`ifndef SEVEN_SEGMENT_DECIMAL_SCAN_CORE_DEFINES_SVH
`define SEVEN_SEGMENT_DECIMAL_SCAN_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SSDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define SSDS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hw/rtl/ssds_pkg.sv
// Types, constants and the segment table of the seven-segment scan core.
`default_nettype none

package ssds_pkg;

  // Display modes carried by the kind field.
  typedef enum logic [1:0] {
    KindLeft  = 2'd0,
    KindRight = 2'd1,
    KindAll   = 2'd2
  } ssds_kind_e;

  localparam logic [15:0] FourDigitMax = 16'd9999;
  localparam int unsigned BcdDigits    = 5;

  typedef struct packed {
    logic [15:0] value;
    logic [1:0]  kind;
  } ssds_in_t;

  typedef struct packed {
    logic [7:0] digit_select_n;
    logic [7:0] segments_n;
    logic [3:0] position;
    logic       overflow;
    logic       last;
  } ssds_out_t;

  // One converted item waiting between the converter and the scanner.
  typedef struct packed {
    logic [BcdDigits-1:0][3:0] digits;   // digit 0 is the units digit
    ssds_kind_e                kind;
    logic                      overflow;
  } ssds_entry_t;

  // Common-cathode pattern, segment a in bit 0 up to segment g in bit 6.
  function automatic logic [7:0] ssds_seg(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/seven_segment_decimal_scan_core.sv
// Top level of the multiplexed seven-segment decimal scan core.
// Throughput: the converter takes two value bits per cycle and takes a new word only
// when it is idle or its finished word moves on to the queue in that cycle; an
// eight-digit scan gives eight strobes, a four-digit scan four.
// Reset: rst_ni clears the converter, queue and scanner control; nothing else needs it.
`default_nettype none
`include "seven_segment_decimal_scan_core_defines.svh"

module seven_segment_decimal_scan_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ssds_pkg::ssds_in_t  in_word_i,
  input  wire logic                push,
  output      logic                full,
  output      ssds_pkg::ssds_out_t out_word_o,
  output      logic                empty,
  input  wire logic                pop
);

  localparam int unsigned EntryW = $bits(ssds_pkg::ssds_entry_t);

  ssds_pkg::ssds_entry_t front_entry, back_entry;
  logic [EntryW-1:0]     queue_rdata;
  logic                  entry_push, entry_full, entry_pop, entry_empty;

  // The front end saturates four-digit values above 9999, then runs a
  // double-dabble conversion two bits per cycle. A finished conversion waits in
  // its registers until the queue has room, and a new word is taken in the
  // same cycle that the finished one moves on.
  ssds_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_word_i    (in_word_i),
    .push_i       (push),
    .full_o       (full),
    .entry_o      (front_entry),
    .entry_push_o (entry_push),
    .entry_full_i (entry_full)
  );

  // The queue lets the converter work on the next word while the scanner is
  // still emitting strobes of the previous one.
  ssds_fifo #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (entry_push),
    .wdata_i (front_entry),
    .full_o  (entry_full),
    .pop_i   (entry_pop),
    .rdata_o (queue_rdata),
    .empty_o (entry_empty)
  );

  assign back_entry = ssds_pkg::ssds_entry_t'(queue_rdata);

  // The scanner walks the positions from left to right, blanking leading zeros
  // across the whole scan, and frees the queue entry with the last strobe. Its
  // output register lets a strobe wait while the next one is prepared.
  ssds_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (back_entry),
    .entry_empty_i (entry_empty),
    .entry_pop_o   (entry_pop),
    .out_word_o    (out_word_o),
    .empty_o       (empty),
    .pop_i         (pop)
  );

  // Exactly one digit is selected on every waiting strobe.
  `SSDS_ASSERT(a_one_cold, empty || $onehot(~out_word_o.digit_select_n), "select not one-cold")
  // The select line agrees with the reported position.
  `SSDS_ASSERT(a_pos_sel,
      empty || (out_word_o.digit_select_n == ~(8'h80 >> (out_word_o.position - 4'd1))),
      "select does not match position")
  // A scan always ends on the fourth or eighth position.
  `SSDS_ASSERT(a_last_pos,
      empty || !out_word_o.last || (out_word_o.position == 4'd4) ||
      (out_word_o.position == 4'd8),
      "last strobe at wrong position")
  // The converter never hands over an item while the queue is full.
  `SSDS_ASSERT_NEVER(a_queue_ovf, entry_push && entry_full, "queue overrun")

endmodule

`default_nettype wire

### hw/rtl/ssds_fifo.sv
// Small register queue between the converter and the scanner.
`default_nettype none

module ssds_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [Width-1:0] rdata_o,
  output      logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ssds_front.sv
// Front end: takes words, saturates and converts the value to decimal digits.
`default_nettype none

module ssds_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ssds_pkg::ssds_in_t in_word_i,
  input  wire logic              push_i,
  output      logic              full_o,
  output      ssds_pkg::ssds_entry_t entry_o,
  output      logic              entry_push_o,
  input  wire logic              entry_full_i
);

  localparam int unsigned BcdW  = 4 * ssds_pkg::BcdDigits;
  localparam logic [3:0]  Steps = 4'd8;   // two value bits per step

  logic              busy_q, busy_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [15:0]       bin_q, bin_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  ssds_pkg::ssds_kind_e kind_q, kind_d;
  logic              ovf_q, ovf_d;
  logic              holding, ready, accept, wide, ovf_in;
  logic [15:0]       sat_value;

  // Two double-dabble iterations: correct each digit, then shift a bit in.
  function automatic logic [BcdW-1:0] dabble2(input logic [BcdW-1:0] bcd,
                                              input logic [1:0] bits);
    logic [BcdW-1:0] acc;
    acc = bcd;
    for (int s = 1; s >= 0; s--) begin
      for (int n = 0; n < ssds_pkg::BcdDigits; n++) begin
        if (acc[4*n +: 4] >= 4'd5) begin
          acc[4*n +: 4] = acc[4*n +: 4] + 4'd3;
        end
      end
      acc = {acc[BcdW-2:0], bits[s]};
    end
    return acc;
  endfunction

  assign holding      = busy_q && (cnt_q == Steps);
  assign entry_push_o = holding && !entry_full_i;
  assign ready        = !busy_q || entry_push_o;
  assign full_o       = !ready;
  assign accept       = push_i && ready;

  assign wide      = (in_word_i.kind == ssds_pkg::KindAll);
  assign ovf_in    = !wide && (in_word_i.value > ssds_pkg::FourDigitMax);
  assign sat_value = ovf_in ? ssds_pkg::FourDigitMax : in_word_i.value;

  assign entry_o.digits   = bcd_q;
  assign entry_o.kind     = kind_q;
  assign entry_o.overflow = ovf_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    kind_d = kind_q;
    ovf_d  = ovf_q;
    if (accept) begin
      // The unused kind code gives no strobes, so it is dropped here.
      busy_d = (in_word_i.kind == ssds_pkg::KindLeft) ||
               (in_word_i.kind == ssds_pkg::KindRight) || wide;
      cnt_d  = 4'd1;
      bin_d  = {sat_value[13:0], 2'b00};
      bcd_d  = dabble2('0, sat_value[15:14]);
      kind_d = ssds_pkg::ssds_kind_e'(in_word_i.kind);
      ovf_d  = ovf_in;
    end else if (entry_push_o) begin
      busy_d = 1'b0;
    end else if (busy_q && (cnt_q != Steps)) begin
      cnt_d = cnt_q + 4'd1;
      bin_d = {bin_q[13:0], 2'b00};
      bcd_d = dabble2(bcd_q, bin_q[15:14]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    kind_q <= kind_d;
    ovf_q  <= ovf_d;
  end

endmodule

`default_nettype wire

### hw/rtl/ssds_back.sv
// Back end: scans one converted item into digit strobes, one per cycle while the output is not held.
`default_nettype none

module ssds_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ssds_pkg::ssds_entry_t entry_i,
  input  wire logic                  entry_empty_i,
  output      logic                  entry_pop_o,
  output      ssds_pkg::ssds_out_t   out_word_o,
  output      logic                  empty_o,
  input  wire logic                  pop_i
);

  logic [2:0]          idx_q, idx_d;
  logic                lead_q, lead_d;
  logic                out_valid_q, out_valid_d;
  ssds_pkg::ssds_out_t out_q, out_d;
  ssds_pkg::ssds_out_t strobe;
  logic                advance, emit, wide, is_last, blank;
  logic [2:0]          nib, pos_m1;
  logic [3:0]          digit;

  assign wide    = (entry_i.kind == ssds_pkg::KindAll);
  assign is_last = (idx_q == (wide ? 3'd7 : 3'd3));
  assign nib     = wide ? (3'd7 - idx_q) : (3'd3 - idx_q);

  always_comb begin
    case (nib)
      3'd0:    digit = entry_i.digits[0];
      3'd1:    digit = entry_i.digits[1];
      3'd2:    digit = entry_i.digits[2];
      3'd3:    digit = entry_i.digits[3];
      3'd4:    digit = entry_i.digits[4];
      default: digit = 4'd0;
    endcase
  end

  assign blank  = lead_q && (digit == 4'd0) && !is_last;
  assign pos_m1 = (entry_i.kind == ssds_pkg::KindRight) ? {1'b1, idx_q[1:0]} : idx_q;

  always_comb begin
    strobe.digit_select_n = ~(8'h80 >> pos_m1);
    strobe.segments_n     = blank ? 8'hFF : ~ssds_pkg::ssds_seg(digit);
    strobe.position       = {1'b0, pos_m1} + 4'd1;
    strobe.overflow       = entry_i.overflow;
    strobe.last           = is_last;
  end

  assign advance     = !out_valid_q || pop_i;
  assign emit        = !entry_empty_i && advance;
  assign entry_pop_o = emit && is_last;
  assign empty_o     = !out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    idx_d       = idx_q;
    lead_d      = lead_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_d       = strobe;
      out_valid_d = 1'b1;
      if (is_last) begin
        idx_d  = '0;
        lead_d = 1'b1;
      end else begin
        idx_d  = idx_q + 3'd1;
        lead_d = blank;
      end
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      lead_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      lead_q      <= lead_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

`default_nettype wire
